@@ rtl/rtt_estimator_rto_assert.svh @@
// assertion macros shared by the rtt estimator rtl
// no dependencies; taken in by include where assertions are written
`ifndef RTT_ESTIMATOR_RTO_ASSERT_SVH
`define RTT_ESTIMATOR_RTO_ASSERT_SVH
`ifndef SYNTH
`define RTTE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define RTTE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RTTE_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define RTTE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

@@ rtl/rtte_pkg.sv @@
// shared types and constants of the rtt estimator
// no dependencies
package rtte_pkg;

    localparam int RTT_BITS     = 24;
    localparam int TIME_BITS    = 48;
    localparam int RTO_BITS     = 26;
    localparam int WIN_BITS     = 32;
    localparam int FRAC_BITS_DEF = 4;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_RTT_WINDOW = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INITIAL_RTO    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_RTO        = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_RTO        = 2'd3;

    localparam logic [WIN_BITS-1:0] WINDOW_RESET      = 32'd10000000;
    localparam logic [RTO_BITS-1:0] INITIAL_RTO_RESET = 26'd1000000;
    localparam logic [RTO_BITS-1:0] MIN_RTO_RESET     = 26'd200000;
    localparam logic [RTO_BITS-1:0] MAX_RTO_RESET     = 26'd60000000;

    typedef struct packed {
        logic                 func;
        logic [RTT_BITS-1:0]  rtt_us;
        logic [TIME_BITS-1:0] now_us;
    } rtte_in_t;

    typedef struct packed {
        logic [RTT_BITS-1:0] srtt_us;
        logic [RTT_BITS-1:0] rttvar_us;
        logic [RTT_BITS-1:0] jitter_us;
        logic [RTT_BITS-1:0] min_rtt_us;
        logic [RTO_BITS-1:0] rto_us;
        logic                has_sample;
    } rtte_out_t;

    typedef struct packed {
        logic [RTO_BITS-1:0] initial_rto;
        logic [RTO_BITS-1:0] min_rto;
        logic [RTO_BITS-1:0] max_rto;
    } rtte_rto_cfg_t;

endpackage

@@ rtl/rtt_estimator_rto.sv @@
// top level of the rtt estimator: beat handshakes, config registers, pipeline control
// depends on rtte_pkg, rtte_filter, rtte_result and rtt_estimator_rto_assert.svh
//
//   channel | ports                                   | moves
//   --------+-----------------------------------------+------------------------------
//   in      | s_valid s_ready s_data                  | one query or rtt sample a beat
//   out     | m_valid m_ready m_data                  | one result beat per input beat
//   config  | cfg_valid cfg_ready cfg_index cfg_data  | one register write a beat
//
// one input beat per cycle unless a stalled result holds the pipeline; each beat passes the stages in order
// stages: input register, state update, result register (clamp of the timeout)
// synchronous active-low reset clears state and restores the register defaults
// a stalled result holds the stages behind it only as far as they are full
// config writes are always taken
`include "rtt_estimator_rto_assert.svh"
module rtt_estimator_rto #(
    parameter int FRAC_BITS = rtte_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rtte_pkg::rtte_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rtte_pkg::rtte_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rtte_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [rtte_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int FW = rtte_pkg::RTT_BITS + FRAC_BITS;

    logic [rtte_pkg::WIN_BITS-1:0] win_reg, win_next;
    rtte_pkg::rtte_rto_cfg_t       rcfg_reg, rcfg_next;

    rtte_pkg::rtte_in_t in_reg;
    logic               v1_reg, v1_next;
    logic               v2_reg, v2_next;
    logic               mv_reg, mv_next;

    logic out_ready, s2_ready, s1_ready, upd_en, load;

    logic [FW-1:0]                 srtt, rttvar, jitter;
    logic [rtte_pkg::RTT_BITS-1:0] win_min, prior_min;
    logic                          seen;

    assign cfg_ready = 1'b1;

    always_comb begin
        win_next  = win_reg;
        rcfg_next = rcfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                rtte_pkg::CFG_MIN_RTT_WINDOW: win_next = cfg_data;
                rtte_pkg::CFG_INITIAL_RTO: rcfg_next.initial_rto = cfg_data[rtte_pkg::RTO_BITS-1:0];
                rtte_pkg::CFG_MIN_RTO: rcfg_next.min_rto = cfg_data[rtte_pkg::RTO_BITS-1:0];
                rtte_pkg::CFG_MAX_RTO: rcfg_next.max_rto = cfg_data[rtte_pkg::RTO_BITS-1:0];
                default: begin
                    win_next = win_reg;
                end
            endcase
        end
    end

    // ready chain from the result register back to the input register
    always_comb begin
        out_ready = !mv_reg || m_ready;
        s2_ready  = !v2_reg || out_ready;
        s1_ready  = !v1_reg || s2_ready;
        upd_en    = v1_reg && s2_ready;
        load      = v2_reg && out_ready;

        v1_next = (s_valid && s1_ready) ? 1'b1 : (upd_en ? 1'b0 : v1_reg);
        v2_next = upd_en ? 1'b1 : (load ? 1'b0 : v2_reg);
        mv_next = load ? 1'b1 : (m_ready ? 1'b0 : mv_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg              <= rtte_pkg::WINDOW_RESET;
            rcfg_reg.initial_rto <= rtte_pkg::INITIAL_RTO_RESET;
            rcfg_reg.min_rto     <= rtte_pkg::MIN_RTO_RESET;
            rcfg_reg.max_rto     <= rtte_pkg::MAX_RTO_RESET;
            v1_reg               <= 1'b0;
            v2_reg               <= 1'b0;
            mv_reg               <= 1'b0;
        end else begin
            win_reg  <= win_next;
            rcfg_reg <= rcfg_next;
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            mv_reg   <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s1_ready) begin
            in_reg <= s_data;
        end
    end

    assign s_ready = s1_ready;
    assign m_valid = mv_reg;

    rtte_filter #(
        .FRAC_BITS (FRAC_BITS)
    ) u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .upd_en    (upd_en),
        .item      (in_reg),
        .window_us (win_reg),
        .srtt      (srtt),
        .rttvar    (rttvar),
        .jitter    (jitter),
        .win_min   (win_min),
        .prior_min (prior_min),
        .seen      (seen)
    );

    rtte_result #(
        .FRAC_BITS (FRAC_BITS)
    ) u_result (
        .aclk      (aclk),
        .load      (load),
        .srtt      (srtt),
        .rttvar    (rttvar),
        .jitter    (jitter),
        .win_min   (win_min),
        .prior_min (prior_min),
        .seen      (seen),
        .rto_cfg   (rcfg_reg),
        .result    (m_data)
    );

    `RTTE_ASSERT_SAME(a_out_from_update, aclk, aresetn, $rose(mv_reg), $past(v2_reg),
        "result beat without an updated item")
    `RTTE_ASSERT_NEXT(a_update_held, aclk, aresetn, v1_reg && !s2_ready, v1_reg && v2_reg,
        "input stage dropped while update stage full")
    `RTTE_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "result beat changed while waiting")

endmodule

@@ rtl/rtte_filter.sv @@
// estimator state and its per-sample update (srtt, rttvar, jitter, windowed minimum)
// depends on rtte_pkg and rtt_estimator_rto_assert.svh
`include "rtt_estimator_rto_assert.svh"
module rtte_filter #(
    parameter int FRAC_BITS = rtte_pkg::FRAC_BITS_DEF,
    localparam int FW = rtte_pkg::RTT_BITS + FRAC_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               upd_en,
    input  rtte_pkg::rtte_in_t                 item,
    input  logic [rtte_pkg::WIN_BITS-1:0]      window_us,
    output logic [FW-1:0]                      srtt,
    output logic [FW-1:0]                      rttvar,
    output logic [FW-1:0]                      jitter,
    output logic [rtte_pkg::RTT_BITS-1:0]      win_min,
    output logic [rtte_pkg::RTT_BITS-1:0]      prior_min,
    output logic                               seen
);

    localparam int RB = rtte_pkg::RTT_BITS;
    localparam int TB = rtte_pkg::TIME_BITS;

    logic          seen_reg, seen_next;
    logic [FW-1:0] srtt_reg, srtt_next;
    logic [FW-1:0] var_reg, var_next;
    logic [FW-1:0] jit_reg, jit_next;
    logic [RB-1:0] prev_reg, prev_next;
    logic [RB-1:0] wmin_reg, wmin_next;
    logic [RB-1:0] prior_reg, prior_next;
    logic [TB-1:0] wbegin_reg, wbegin_next;

    logic [FW-1:0] r;
    logic [FW-1:0] dev;
    logic [RB-1:0] rtt_delta;
    logic [FW-1:0] d;
    logic [FW+1:0] sum_v;
    logic [FW+2:0] sum_s;
    logic [FW+3:0] sum_j;
    logic [TB-1:0] elapsed;
    logic          expired;

    always_comb begin
        r         = {item.rtt_us, {FRAC_BITS{1'b0}}};
        dev       = (srtt_reg >= r) ? (srtt_reg - r) : (r - srtt_reg);
        rtt_delta = (item.rtt_us >= prev_reg) ? (item.rtt_us - prev_reg)
                                              : (prev_reg - item.rtt_us);
        d         = {rtt_delta, {FRAC_BITS{1'b0}}};
        sum_v     = ({2'b00, var_reg} << 1) + {2'b00, var_reg} + {2'b00, dev};
        sum_s     = ({3'b000, srtt_reg} << 3) - {3'b000, srtt_reg} + {3'b000, r};
        sum_j     = ({4'b0000, jit_reg} << 4) - {4'b0000, jit_reg} + {4'b0000, d};
        elapsed   = item.now_us - wbegin_reg;
        expired   = elapsed >= {{(TB-rtte_pkg::WIN_BITS){1'b0}}, window_us};
    end

    always_comb begin
        seen_next   = seen_reg;
        srtt_next   = srtt_reg;
        var_next    = var_reg;
        jit_next    = jit_reg;
        prev_next   = prev_reg;
        wmin_next   = wmin_reg;
        prior_next  = prior_reg;
        wbegin_next = wbegin_reg;
        if (upd_en && item.func) begin
            prev_next = item.rtt_us;
            if (!seen_reg) begin
                seen_next   = 1'b1;
                srtt_next   = r;
                var_next    = r >> 1;
                wmin_next   = item.rtt_us;
                prior_next  = item.rtt_us;
                wbegin_next = item.now_us;
            end else begin
                var_next  = sum_v[FW+1:2];
                srtt_next = sum_s[FW+2:3];
                jit_next  = sum_j[FW+3:4];
                if (expired) begin
                    prior_next  = wmin_reg;
                    wmin_next   = item.rtt_us;
                    wbegin_next = item.now_us;
                end else if (item.rtt_us < wmin_reg) begin
                    wmin_next = item.rtt_us;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg   <= 1'b0;
            srtt_reg   <= '0;
            var_reg    <= '0;
            jit_reg    <= '0;
            prev_reg   <= '0;
            wmin_reg   <= '0;
            prior_reg  <= '0;
            wbegin_reg <= '0;
        end else begin
            seen_reg   <= seen_next;
            srtt_reg   <= srtt_next;
            var_reg    <= var_next;
            jit_reg    <= jit_next;
            prev_reg   <= prev_next;
            wmin_reg   <= wmin_next;
            prior_reg  <= prior_next;
            wbegin_reg <= wbegin_next;
        end
    end

    assign srtt      = srtt_reg;
    assign rttvar    = var_reg;
    assign jitter    = jit_reg;
    assign win_min   = wmin_reg;
    assign prior_min = prior_reg;
    assign seen      = seen_reg;

    `RTTE_ASSERT_NEXT(a_seen_sticky, aclk, aresetn, seen_reg, seen_reg, "sample flag cleared")
    `RTTE_ASSERT_NEXT(a_first_seed, aclk, aresetn, upd_en && item.func && !seen_reg,
        srtt_reg == {$past(item.rtt_us), {FRAC_BITS{1'b0}}} && prior_reg == wmin_reg,
        "first sample did not seed the filters")
    `RTTE_ASSERT_SAME(a_idle_filters, aclk, aresetn, !seen_reg,
        srtt_reg == '0 && var_reg == '0 && jit_reg == '0, "filters moved before a sample")

endmodule

@@ rtl/rtte_result.sv @@
// result register: output scaling, minimum rtt and clamped timeout
// depends on rtte_pkg
module rtte_result #(
    parameter int FRAC_BITS = rtte_pkg::FRAC_BITS_DEF,
    localparam int FW = rtte_pkg::RTT_BITS + FRAC_BITS
) (
    input  logic                           aclk,
    input  logic                           load,
    input  logic [FW-1:0]                  srtt,
    input  logic [FW-1:0]                  rttvar,
    input  logic [FW-1:0]                  jitter,
    input  logic [rtte_pkg::RTT_BITS-1:0]  win_min,
    input  logic [rtte_pkg::RTT_BITS-1:0]  prior_min,
    input  logic                           seen,
    input  rtte_pkg::rtte_rto_cfg_t        rto_cfg,
    output rtte_pkg::rtte_out_t            result
);

    localparam int RAWB = rtte_pkg::RTT_BITS + 3;
    localparam int OB   = rtte_pkg::RTO_BITS;

    rtte_pkg::rtte_out_t out_reg, out_next;

    logic [FW+2:0]   rto_sum;
    logic [RAWB-1:0] raw;
    logic [RAWB-1:0] lo_b;
    logic [RAWB-1:0] hi_b;
    logic [RAWB-1:0] raised;
    logic [OB-1:0]   rto;

    always_comb begin
        rto_sum = {3'b000, srtt} + ({3'b000, rttvar} << 2);
        lo_b    = {{(RAWB-OB){1'b0}}, rto_cfg.min_rto};
        hi_b    = {{(RAWB-OB){1'b0}}, rto_cfg.max_rto};
        raw     = seen ? rto_sum[FW+2:FRAC_BITS]
                       : {{(RAWB-OB){1'b0}}, rto_cfg.initial_rto};
        raised  = (raw < lo_b) ? lo_b : raw;
        rto     = (raised > hi_b) ? rto_cfg.max_rto : raised[OB-1:0];

        out_next.srtt_us    = srtt[FW-1:FRAC_BITS];
        out_next.rttvar_us  = rttvar[FW-1:FRAC_BITS];
        out_next.jitter_us  = jitter[FW-1:FRAC_BITS];
        out_next.min_rtt_us = (win_min < prior_min) ? win_min : prior_min;
        out_next.rto_us     = rto;
        out_next.has_sample = seen;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule

@@ test/tb_rtt_estimator_rto.sv @@
// self-checking testbench for rtt_estimator_rto: directed and random beats with
// random idling on both channels, results checked against an in-bench estimate model
// depends on rtte_pkg and the rtt_estimator_rto rtl
module tb_rtt_estimator_rto;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int RB = rtte_pkg::RTT_BITS;
    localparam int TB = rtte_pkg::TIME_BITS;
    localparam int FB = rtte_pkg::FRAC_BITS_DEF;
    localparam int IB = rtte_pkg::CFG_IDX_BITS;
    localparam int DB = rtte_pkg::CFG_DATA_BITS;

    class rtt_tracker;
        localparam int FW = RB + FB;

        logic [rtte_pkg::WIN_BITS-1:0] window_len;
        logic [rtte_pkg::RTO_BITS-1:0] start_rto;
        logic [rtte_pkg::RTO_BITS-1:0] rto_floor;
        logic [rtte_pkg::RTO_BITS-1:0] rto_ceil;
        logic                          seen;
        logic [FW-1:0]                 srtt_fx;
        logic [FW-1:0]                 rvar_fx;
        logic [FW-1:0]                 jitter_fx;
        logic [RB-1:0]                 last_rtt;
        logic [RB-1:0]                 win_min;
        logic [RB-1:0]                 prior_min;
        logic [TB-1:0]                 win_start;
        rtte_pkg::rtte_out_t           due[$];
        int                            errors;

        function new();
            window_len = rtte_pkg::WINDOW_RESET;
            start_rto  = rtte_pkg::INITIAL_RTO_RESET;
            rto_floor  = rtte_pkg::MIN_RTO_RESET;
            rto_ceil   = rtte_pkg::MAX_RTO_RESET;
            seen       = 1'b0;
            srtt_fx    = '0;
            rvar_fx    = '0;
            jitter_fx  = '0;
            last_rtt   = '0;
            win_min    = '0;
            prior_min  = '0;
            win_start  = '0;
            errors     = 0;
        endfunction

        function void set_reg(logic [IB-1:0] idx, logic [DB-1:0] value);
            case (idx)
                rtte_pkg::CFG_MIN_RTT_WINDOW: window_len = value;
                rtte_pkg::CFG_INITIAL_RTO:    start_rto  = value[rtte_pkg::RTO_BITS-1:0];
                rtte_pkg::CFG_MIN_RTO:        rto_floor  = value[rtte_pkg::RTO_BITS-1:0];
                rtte_pkg::CFG_MAX_RTO:        rto_ceil   = value[rtte_pkg::RTO_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void absorb(rtte_pkg::rtte_in_t beat);
            logic [FW-1:0]       sample_fx;
            logic [FW-1:0]       dev;
            logic [FW-1:0]       step;
            logic [RB-1:0]       gap;
            logic [TB-1:0]       elapsed;
            logic [FW+5:0]       acc;
            logic [FW+2:0]       rto;
            rtte_pkg::rtte_out_t want;
            if (beat.func) begin
                sample_fx = {beat.rtt_us, {FB{1'b0}}};
                if (!seen) begin
                    srtt_fx   = sample_fx;
                    rvar_fx   = sample_fx >> 1;
                    win_min   = beat.rtt_us;
                    prior_min = beat.rtt_us;
                    win_start = beat.now_us;
                    seen      = 1'b1;
                end else begin
                    dev = (srtt_fx >= sample_fx) ? srtt_fx - sample_fx : sample_fx - srtt_fx;
                    gap = (beat.rtt_us >= last_rtt) ? beat.rtt_us - last_rtt
                                                    : last_rtt - beat.rtt_us;
                    step = {gap, {FB{1'b0}}};
                    elapsed = beat.now_us - win_start;
                    acc = (FW+6)'(rvar_fx) * 3 + (FW+6)'(dev);
                    rvar_fx = acc[FW+1:2];
                    acc = (FW+6)'(srtt_fx) * 7 + (FW+6)'(sample_fx);
                    srtt_fx = acc[FW+2:3];
                    acc = (FW+6)'(jitter_fx) * 15 + (FW+6)'(step);
                    jitter_fx = acc[FW+3:4];
                    if (elapsed >= TB'(window_len)) begin
                        prior_min = win_min;
                        win_min   = beat.rtt_us;
                        win_start = beat.now_us;
                    end else if (beat.rtt_us < win_min) begin
                        win_min = beat.rtt_us;
                    end
                end
                last_rtt = beat.rtt_us;
            end
            if (seen) begin
                rto = ((FW+3)'(srtt_fx) + ((FW+3)'(rvar_fx) << 2)) >> FB;
            end else begin
                rto = (FW+3)'(start_rto);
            end
            if (rto < rto_floor) rto = rto_floor;
            if (rto > rto_ceil) rto = rto_ceil;
            want.srtt_us    = srtt_fx[FW-1:FB];
            want.rttvar_us  = rvar_fx[FW-1:FB];
            want.jitter_us  = jitter_fx[FW-1:FB];
            want.min_rtt_us = (win_min < prior_min) ? win_min : prior_min;
            want.rto_us     = rto[rtte_pkg::RTO_BITS-1:0];
            want.has_sample = seen;
            due.push_back(want);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            if (errors < 40) $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task compare(rtte_pkg::rtte_out_t got);
            rtte_pkg::rtte_out_t want;
            if (due.size() == 0) begin
                report("result beat with none outstanding", 64'(got), 64'd0);
                return;
            end
            want = due.pop_front();
            if (got.srtt_us !== want.srtt_us) report("srtt_us", got.srtt_us, want.srtt_us);
            if (got.rttvar_us !== want.rttvar_us) report("rttvar_us", got.rttvar_us, want.rttvar_us);
            if (got.jitter_us !== want.jitter_us) report("jitter_us", got.jitter_us, want.jitter_us);
            if (got.min_rtt_us !== want.min_rtt_us)
                report("min_rtt_us", got.min_rtt_us, want.min_rtt_us);
            if (got.rto_us !== want.rto_us) report("rto_us", got.rto_us, want.rto_us);
            if (got.has_sample !== want.has_sample)
                report("has_sample", got.has_sample, want.has_sample);
        endtask
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    rtte_pkg::rtte_in_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    rtte_pkg::rtte_out_t m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IB-1:0]       cfg_index = '0;
    logic [DB-1:0]       cfg_data = '0;

    rtt_tracker    book;
    int            s_idle_pct = 0;
    int            m_idle_pct = 0;
    int            hold_left = 0;
    logic          long_stall_pending = 1'b0;
    logic          long_stall_taken = 1'b0;
    int unsigned   cycle_count = 0;
    logic [TB-1:0] clock_us = '0;
    int unsigned   base_rtt = 1000;
    int unsigned   spread = 250;
    int unsigned   step_max = 500;

    rtt_estimator_rto dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4;
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: random back-pressure plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_stall_pending && !long_stall_taken) begin
            m_ready          <= 1'b0;
            hold_left        <= 400;
            long_stall_taken <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) book.compare(m_data);
    end

    task automatic offer(input logic func, input logic [RB-1:0] rtt,
                         input logic [TB-1:0] at_us);
        rtte_pkg::rtte_in_t beat;
        beat.func   = func;
        beat.rtt_us = rtt;
        beat.now_us = at_us;
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        book.absorb(beat);
    endtask

    task automatic offer_random();
        int unsigned   roll;
        logic          func;
        logic [RB-1:0] rtt;
        logic [63:0]   wide;
        roll = $urandom_range(99);
        func = ($urandom_range(99) < 85);
        if (roll < 4) begin
            wide = {$urandom, $urandom};
            clock_us = wide[TB-1:0];
        end else begin
            clock_us = clock_us + $urandom_range(0, step_max);
        end
        if (roll >= 4 && roll < 14) rtt = RB'($urandom);
        else rtt = RB'(base_rtt + $urandom_range(0, spread));
        offer(func, rtt, clock_us);
    endtask

    task automatic write_reg(input logic [IB-1:0] idx, input logic [DB-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        book.set_reg(idx, value);
    endtask

    task automatic configure(input logic [31:0] win, input logic [31:0] init_rto,
                             input logic [31:0] floor_rto, input logic [31:0] ceil_rto);
        write_reg(rtte_pkg::CFG_MIN_RTT_WINDOW, win);
        write_reg(rtte_pkg::CFG_INITIAL_RTO, init_rto);
        write_reg(rtte_pkg::CFG_MIN_RTO, floor_rto);
        write_reg(rtte_pkg::CFG_MAX_RTO, ceil_rto);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (book.due.size() != 0) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] lo;
        book = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // queries before any sample, timeout taken from the initial value and clamped to the bounds
        offer(1'b0, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF);
        offer(1'b0, 24'h00_0000, 48'h0);
        settle();
        configure(32'd10000000, 32'hFFFF_FFFF, 32'd0, 32'd60000000);
        offer(1'b0, 24'h5A_5A5A, 48'h0);
        settle();
        configure(32'd10000000, 32'd0, 32'd200000, 32'h03FF_FFFF);
        offer(1'b0, 24'hA5_A5A5, 48'h1);
        settle();
        configure(32'd1000, 32'd500, 32'd1000, 32'd100);
        offer(1'b0, 24'h00_0001, 48'h2);
        settle();

        // first sample at full scale, then swings, time wrap and a backwards step
        configure(32'd1000, 32'd1000000, 32'd0, 32'h03FF_FFFF);
        offer(1'b1, 24'hFF_FFFF, 48'd100);
        offer(1'b1, 24'h00_0000, 48'd200);
        offer(1'b1, 24'hFF_FFFF, 48'd300);
        offer(1'b0, 24'h12_3456, 48'd300);
        offer(1'b1, 24'd1, 48'd1500);
        offer(1'b1, 24'd0, 48'd1500);
        offer(1'b1, 24'd7, 48'hFFFF_FFFF_FFFF);
        offer(1'b1, 24'd3, 48'd50000);
        offer(1'b1, 24'd3, 48'd50000);
        settle();
        configure(32'd0, 32'd1000000, 32'd200000, 32'd60000000);
        offer(1'b1, 24'd900, 48'd50000);
        offer(1'b1, 24'd400, 48'd50000);
        offer(1'b1, 24'd800, 48'd50001);
        settle();
        configure(32'hFFFF_FFFF, 32'd1000000, 32'd200000, 32'd60000000);
        offer(1'b1, 24'd100, 48'd0);
        offer(1'b1, 24'd50, 48'd10);
        clock_us = 48'd10;

        for (int ph = 0; ph < 3; ph++) begin
            s_idle_pct <= (ph == 0) ? 24 : (ph == 1) ? 75 : 0;
            m_idle_pct <= (ph == 0) ? 75 : (ph == 1) ? 24 : 0;
            for (int k = 0; k < 2; k++) begin
                settle();
                base_rtt = $urandom_range(1, 8000000) >> $urandom_range(0, 20);
                spread   = base_rtt / 4 + 1;
                step_max = $urandom_range(0, 1) ? 500 : 20000;
                lo       = $urandom_range(0, 300000);
                case (ph * 2 + k)
                    0: configure(32'd1, $urandom_range(0, 67108863), 32'd0, 32'h03FF_FFFF);
                    1: configure(32'd0, $urandom, lo, $urandom_range(lo, 67108863));
                    2: configure(32'hFFFF_FFFF, $urandom, $urandom, $urandom);
                    3: configure(32'd5000, 32'd0, 32'd0, 32'd0);
                    4: configure($urandom_range(1000, 300000), rtte_pkg::INITIAL_RTO_RESET,
                                 rtte_pkg::MIN_RTO_RESET, rtte_pkg::MAX_RTO_RESET);
                    default: configure($urandom, $urandom, lo, 32'h03FF_FFFF);
                endcase
                if (ph == 2 && k == 0) begin
                    repeat (50) offer_random();
                    long_stall_pending <= 1'b1;
                    repeat (165) offer_random();
                end else begin
                    repeat (215) offer_random();
                end
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        if (book.errors == 0 && book.due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
